// ===== rtl/sbsh_pkg.sv =====
// ============================================================================
// sbsh_pkg
// Shared types and constants for the selectable byte stream hash core.
// ============================================================================
`default_nettype none

package sbsh_pkg;

    localparam int HASH_WIDTH_DEF = 64;
    localparam int OUT_W          = 64;
    localparam int BYTE_W         = 8;
    localparam int MODE_W         = 2;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_BKDR = 2'd0;
    localparam mode_t MODE_RS   = 2'd1;
    localparam mode_t MODE_FNV  = 2'd2;
    localparam mode_t MODE_DJB  = 2'd3;

    localparam logic [63:0] BKDR_MUL  = 64'd131313;
    localparam logic [63:0] RS_STEP   = 64'd378551;
    localparam logic [63:0] RS_START  = 64'd63689;
    localparam logic [63:0] FNV_SEED  = 64'd2166136261;
    localparam logic [63:0] FNV_PRIME = 64'd16777619;
    localparam logic [63:0] DJB_SEED  = 64'd5381;
    localparam logic [63:0] DJB_MUL   = 64'd33;

    typedef struct packed {
        logic  in_message;
        mode_t mode;
    } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sbsh_wrap_mul.sv =====
// ============================================================================
// sbsh_wrap_mul
// Wrapping multiplier: low WIDTH bits of a full product, built from half-width
// partial products (the high cross terms are dropped by the wrap).
// ============================================================================
`default_nettype none

module sbsh_wrap_mul
    import sbsh_pkg::*;
#(
    parameter int WIDTH = HASH_WIDTH_DEF
) (
    input  wire logic [WIDTH-1:0] op_a,
    input  wire logic [WIDTH-1:0] op_b,
    output logic      [WIDTH-1:0] product
);

    localparam int LO_W = (WIDTH + 1) / 2;
    localparam int HI_W = WIDTH - LO_W;

    logic [LO_W-1:0]   a_lo;
    logic [HI_W-1:0]   a_hi;
    logic [LO_W-1:0]   b_lo;
    logic [HI_W-1:0]   b_hi;
    logic [2*LO_W-1:0] pp_ll;
    logic [HI_W-1:0]   pp_lh;
    logic [HI_W-1:0]   pp_hl;
    logic [HI_W-1:0]   cross_sum;

    assign a_lo = op_a[LO_W-1:0];
    assign a_hi = op_a[WIDTH-1:LO_W];
    assign b_lo = op_b[LO_W-1:0];
    assign b_hi = op_b[WIDTH-1:LO_W];

    assign pp_ll     = (2*LO_W)'(a_lo) * (2*LO_W)'(b_lo);
    assign pp_lh     = HI_W'(a_lo * LO_W'(b_hi));
    assign pp_hl     = HI_W'(LO_W'(a_hi) * b_lo);
    assign cross_sum = pp_lh + pp_hl;

    assign product = WIDTH'(pp_ll) + {cross_sum, {LO_W{1'b0}}};

endmodule

`default_nettype wire

// ===== rtl/sbsh_hash_step.sv =====
// ============================================================================
// sbsh_hash_step
// One hash round: seeds a new message, updates the accumulator (multiply-add,
// or XOR then multiply for FNV-1a) and, in RS mode, advances the RS factor.
// ============================================================================
`default_nettype none

module sbsh_hash_step
    import sbsh_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
    input  wire ctrl_t                   ctrl,
    input  wire mode_t                   in_mode,
    input  wire logic [BYTE_W-1:0]       data_byte,
    input  wire logic [HASH_WIDTH-1:0]   acc,
    input  wire logic [HASH_WIDTH-1:0]   factor,
    output mode_t                        eff_mode,
    output logic      [HASH_WIDTH-1:0]   acc_next,
    output logic      [HASH_WIDTH-1:0]   factor_next
);

    logic [HASH_WIDTH-1:0] base_acc;
    logic [HASH_WIDTH-1:0] base_factor;
    logic [HASH_WIDTH-1:0] seed;
    logic [HASH_WIDTH-1:0] byte_ext;
    logic [HASH_WIDTH-1:0] rs_prod;

    assign eff_mode    = ctrl.in_message ? ctrl.mode : in_mode;
    assign byte_ext    = HASH_WIDTH'(data_byte);
    assign base_acc    = ctrl.in_message ? acc : seed;
    assign base_factor = ctrl.in_message ? factor : HASH_WIDTH'(RS_START);

    always_comb
    begin
        unique case (eff_mode)
            MODE_FNV: seed = HASH_WIDTH'(FNV_SEED);
            MODE_DJB: seed = HASH_WIDTH'(DJB_SEED);
            default:  seed = '0;
        endcase
    end

    sbsh_wrap_mul #(
        .WIDTH (HASH_WIDTH)
    ) u_rs_mul (
        .op_a    (base_acc),
        .op_b    (base_factor),
        .product (rs_prod)
    );

    always_comb
    begin
        factor_next = base_factor;
        unique case (eff_mode)
            MODE_BKDR:
            begin
                acc_next = HASH_WIDTH'(base_acc * HASH_WIDTH'(BKDR_MUL)) + byte_ext;
            end
            MODE_RS:
            begin
                acc_next    = rs_prod + byte_ext;
                factor_next = HASH_WIDTH'(base_factor * HASH_WIDTH'(RS_STEP));
            end
            MODE_FNV:
            begin
                acc_next = HASH_WIDTH'((base_acc ^ byte_ext) * HASH_WIDTH'(FNV_PRIME));
            end
            default:
            begin
                acc_next = HASH_WIDTH'(base_acc * HASH_WIDTH'(DJB_MUL)) + byte_ext;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/selectable_byte_stream_hash_core.sv =====
// ============================================================================
// selectable_byte_stream_hash_core
// Byte stream hash with per-message choice of BKDR, RS, FNV-1a or DJB2.
// ============================================================================
// Output: a hash word is registered on the output when its last byte leaves
// the input register, which holds that byte while a prior result is untaken.
// Throughput: one byte per cycle in every mode unless a last byte waits; the
// accumulator update, fed back from its own register, sets this rate.
// Reset clears the input and result valids and the message state.
// ============================================================================
`default_nettype none

module selectable_byte_stream_hash_core
    import sbsh_pkg::*;
#(
    parameter int HASH_WIDTH = HASH_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tlast,
    input  wire logic [MODE_W-1:0] s_axis_tuser,   // [1:0] mode
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_W-1:0]  m_axis_tdata    // [63:0] hash_value
);

    logic                  in_vld_reg;
    logic [BYTE_W-1:0]     in_byte_reg;
    logic                  in_last_reg;
    mode_t                 in_mode_reg;

    ctrl_t                 ctrl_reg;
    ctrl_t                 ctrl_next;
    logic [HASH_WIDTH-1:0] acc_reg;
    logic [HASH_WIDTH-1:0] acc_next;
    logic [HASH_WIDTH-1:0] factor_reg;
    logic [HASH_WIDTH-1:0] factor_next;
    mode_t                 eff_mode;

    logic                  out_vld_reg;
    logic [HASH_WIDTH-1:0] hash_reg;

    logic                  out_free;
    logic                  advance;
    logic                  accept;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_vld_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
            in_mode_reg <= s_axis_tuser;
        end
    end

    sbsh_hash_step #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_step (
        .ctrl        (ctrl_reg),
        .in_mode     (in_mode_reg),
        .data_byte   (in_byte_reg),
        .acc         (acc_reg),
        .factor      (factor_reg),
        .eff_mode    (eff_mode),
        .acc_next    (acc_next),
        .factor_next (factor_next)
    );

    assign ctrl_next.in_message = !in_last_reg;
    assign ctrl_next.mode       = eff_mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg    <= acc_next;
            factor_reg <= factor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            hash_reg <= acc_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_W'(hash_reg);

    a_last_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> m_axis_tvalid)
        else $error("last byte did not produce a result word");

    a_mid_keeps_message: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && !in_last_reg) |=> ctrl_reg.in_message)
        else $error("message state lost after a middle byte");

    a_last_clears_message: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> !ctrl_reg.in_message)
        else $error("message state not cleared after last byte");

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_vld_reg && in_last_reg && out_vld_reg))
        else $error("input stalled without a pending result");

    a_mode_held_in_message: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && ctrl_reg.in_message) |=> (ctrl_reg.mode == $past(ctrl_reg.mode)))
        else $error("latched mode changed within a message");

endmodule

`default_nettype wire
